>>> sv/jdlb_pkg.sv
// Shared types and constants for the job dispatch load balancer.
// No dependencies; imported by job_dispatch_load_balancer.
package jdlb_pkg;

  localparam int TIME_W = 40;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 16;
  localparam int SRV_W  = 2;
  localparam int SVC_W  = 32;
  localparam int KEY_W  = 33;
  localparam int INV_LANES = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    POL_RR      = 3'd0,
    POL_PATTERN = 3'd1,
    POL_JSQ     = 3'd2,
    POL_SED     = 3'd3,
    POL_LWL     = 3'd4,
    POL_SITA    = 3'd5
  } policy_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_DONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_POLICY    = 3'd0,
    CFG_ACTIVE    = 3'd1,
    CFG_INV_RATES = 3'd2,
    CFG_THRESH    = 3'd3,
    CFG_ORDER     = 3'd4,
    CFG_DEADLINE  = 3'd5
  } cfg_reg_e;

  localparam logic KIND_ARRIVAL = 1'b0;

  localparam logic [2:0]        POLICY_RST   = 3'd2;
  localparam logic [2:0]        ACTIVE_RST   = 3'd2;
  localparam logic [63:0]       INV_RST      = 64'd0;
  localparam logic [47:0]       THRESH_RST   = 48'd0;
  localparam logic [7:0]        ORDER_RST    = 8'd228;
  localparam logic [TIME_W-1:0] DEADLINE_RST = 40'd131072;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] job_size;
    logic [TIME_W-1:0] arrival_time;
    logic [SRV_W-1:0]  done_server;
  } item_t;

  // pattern 0,1,0,2
  function automatic logic [SRV_W-1:0] pattern_pick(input logic [1:0] phase);
    logic [SRV_W-1:0] pick;
    case (phase)
      2'd1:    pick = 2'd1;
      2'd3:    pick = 2'd2;
      default: pick = 2'd0;
    endcase
    return pick;
  endfunction

endpackage

>>> sv/job_dispatch_load_balancer.sv
// Job dispatch load balancer top level: input register, single-pass policy
// decision and booking, result register. Depends on jdlb_pkg.
//
// Takes one word per clock while the output is not stalled and returns one
// result word per accepted word. Each accepted word passes through the input
// register and then the result register. The decision for each item is made
// against the per-server counts and busy-until times left by the item before
// it, so the sustained rate is one item per cycle when the output does not
// stall. Configuration must only be written while no item is in flight.
module job_dispatch_load_balancer
  import jdlb_pkg::*;
#(
  parameter int NUM_SERVERS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // job_size[15:0], arrival_time[55:16], done_server[57:56]
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // chosen_server[1:0], wait_time[41:2],
                                      // sojourn_time[81:42], late[82], jobs_after[98:83]
  output logic [1:0]   m_axis_tuser   // status
);

  localparam int SEL_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam logic [2:0] NSRV = 3'(NUM_SERVERS);

  // configuration
  logic [2:0]        policy_q, active_q;
  logic [63:0]       inv_rates_q;
  logic [47:0]       thresh_q;
  logic [7:0]        order_q;
  logic [TIME_W-1:0] deadline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POLICY_RST;
      active_q    <= ACTIVE_RST;
      inv_rates_q <= INV_RST;
      thresh_q    <= THRESH_RST;
      order_q     <= ORDER_RST;
      deadline_q  <= DEADLINE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY:    policy_q    <= cfg_data_i[2:0];
        CFG_ACTIVE:    active_q    <= cfg_data_i[2:0];
        CFG_INV_RATES: inv_rates_q <= cfg_data_i;
        CFG_THRESH:    thresh_q    <= cfg_data_i[47:0];
        CFG_ORDER:     order_q     <= cfg_data_i[7:0];
        CFG_DEADLINE:  deadline_q  <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic  s1_valid_q;
  item_t s1_q;
  logic  fire;

  assign fire          = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q.kind         <= s_axis_tuser;
      s1_q.job_size     <= s_axis_tdata[15:0];
      s1_q.arrival_time <= s_axis_tdata[55:16];
      s1_q.done_server  <= s_axis_tdata[57:56];
    end
  end

  // server state
  logic [CNT_W-1:0]  cnt_q  [NUM_SERVERS];
  logic [CNT_W-1:0]  cnt_d  [NUM_SERVERS];
  logic [TIME_W-1:0] busy_q [NUM_SERVERS];
  logic [TIME_W-1:0] busy_d [NUM_SERVERS];
  logic [SRV_W-1:0]  rr_q, rr_d;
  logic [1:0]        phase_q, phase_d;

  // decision
  logic [2:0]        n_act;
  logic [SIZE_W-1:0] inv [INV_LANES];
  logic [KEY_W-1:0]  key_sed [NUM_SERVERS];
  logic [TIME_W-1:0] start_t [NUM_SERVERS];
  logic [SVC_W-1:0]  svc [NUM_SERVERS];
  logic [2:0]        rr_nx;
  logic [SRV_W-1:0]  best;
  logic [KEY_W-1:0]  bk_sed;
  logic [TIME_W-1:0] bk_lwl;
  logic [CNT_W-1:0]  bk_cnt;
  logic [SEL_W-1:0]  bi;

  always_comb begin
    n_act = active_q;
    if (n_act == 3'd0) n_act = 3'd1;
    if (n_act > NSRV) n_act = NSRV;
  end

  always_comb begin
    for (int i = 0; i < INV_LANES; i++) begin
      inv[i] = inv_rates_q[16*i +: 16];
    end
  end

  for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_keys
    logic [CNT_W:0] cp1;
    assign cp1        = {1'b0, cnt_q[g]} + 17'd1;
    assign key_sed[g] = cp1 * inv[g];
    assign start_t[g] = (busy_q[g] > s1_q.arrival_time) ? busy_q[g] : s1_q.arrival_time;
    assign svc[g]     = s1_q.job_size * inv[g];
  end

  always_comb begin
    best   = '0;
    rr_d   = rr_q;
    phase_d = phase_q;
    rr_nx  = {1'b0, rr_q} + 3'd1;
    if (rr_nx >= n_act) rr_nx = 3'd0;
    bk_sed = key_sed[0];
    bk_lwl = start_t[0];
    bk_cnt = cnt_q[0];
    case (policy_q)
      POL_RR: begin
        best = rr_nx[SRV_W-1:0];
        rr_d = rr_nx[SRV_W-1:0];
      end
      POL_PATTERN: begin
        best    = pattern_pick(phase_q);
        phase_d = phase_q + 2'd1;
      end
      POL_SED: begin
        for (int i = 1; i < NUM_SERVERS; i++) begin
          if (3'(i) < n_act && key_sed[i] < bk_sed) begin
            bk_sed = key_sed[i];
            best   = SRV_W'(i);
          end
        end
      end
      POL_LWL: begin
        for (int i = 1; i < NUM_SERVERS; i++) begin
          if (3'(i) < n_act && start_t[i] < bk_lwl) begin
            bk_lwl = start_t[i];
            best   = SRV_W'(i);
          end
        end
      end
      POL_SITA: begin
        best = order_q[1:0];
        for (int i = 1; i < NUM_SERVERS; i++) begin
          if (3'(i) < n_act && s1_q.job_size > thresh_q[16*(i-1) +: 16]) begin
            best = order_q[2*i +: 2];
          end
        end
      end
      default: begin
        for (int i = 1; i < NUM_SERVERS; i++) begin
          if (3'(i) < n_act && cnt_q[i] < bk_cnt) begin
            bk_cnt = cnt_q[i];
            best   = SRV_W'(i);
          end
        end
      end
    endcase
    if ({1'b0, best} >= n_act) best = '0;
    bi = best[SEL_W-1:0];
    if (!(fire && s1_q.kind == KIND_ARRIVAL)) begin
      rr_d    = rr_q;
      phase_d = phase_q;
    end
  end

  // booking
  logic [TIME_W-1:0] start_sel, wait_t, soj_t, fin_t;
  logic [TIME_W:0]   soj_w, fin_w;
  logic [SVC_W-1:0]  svc_sel;
  logic [CNT_W-1:0]  cnt_inc;
  logic              late_t;
  logic              ds_in, ds_ok;
  logic [SEL_W-1:0]  di;
  logic [CNT_W-1:0]  cnt_dec;

  assign start_sel = start_t[bi];
  assign svc_sel   = svc[bi];
  assign wait_t    = start_sel - s1_q.arrival_time;
  assign soj_w     = {1'b0, wait_t} + (TIME_W+1)'(svc_sel);
  assign fin_w     = {1'b0, start_sel} + (TIME_W+1)'(svc_sel);
  assign soj_t     = soj_w[TIME_W] ? TIME_MAX : soj_w[TIME_W-1:0];
  assign fin_t     = fin_w[TIME_W] ? TIME_MAX : fin_w[TIME_W-1:0];
  assign late_t    = soj_t > deadline_q;
  assign cnt_inc   = (cnt_q[bi] == CNT_MAX) ? cnt_q[bi] : cnt_q[bi] + 16'd1;

  assign ds_in   = {1'b0, s1_q.done_server} < NSRV;
  assign di      = ds_in ? s1_q.done_server[SEL_W-1:0] : '0;
  assign ds_ok   = ds_in && (cnt_q[di] != '0);
  assign cnt_dec = cnt_q[di] - 16'd1;

  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      cnt_d[i]  = cnt_q[i];
      busy_d[i] = busy_q[i];
    end
    if (fire) begin
      if (s1_q.kind == KIND_ARRIVAL) begin
        cnt_d[bi]  = cnt_inc;
        busy_d[bi] = fin_t;
      end else if (ds_ok) begin
        cnt_d[di] = cnt_dec;
        if (cnt_dec == '0) busy_d[di] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        cnt_q[i]  <= '0;
        busy_q[i] <= '0;
      end
      rr_q    <= SRV_W'(NUM_SERVERS - 1);
      phase_q <= 2'd0;
    end else begin
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      rr_q    <= rr_d;
      phase_q <= phase_d;
    end
  end

  // result register
  logic [SRV_W-1:0]  chosen_q;
  logic [TIME_W-1:0] wait_q, soj_q;
  logic              late_q;
  logic [CNT_W-1:0]  jobs_q;
  status_e           status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (s1_q.kind == KIND_ARRIVAL) begin
        chosen_q <= best;
        wait_q   <= wait_t;
        soj_q    <= soj_t;
        late_q   <= late_t;
        jobs_q   <= cnt_inc;
        status_q <= ST_PLACED;
      end else begin
        chosen_q <= s1_q.done_server;
        wait_q   <= '0;
        soj_q    <= '0;
        late_q   <= 1'b0;
        jobs_q   <= ds_ok ? cnt_dec : '0;
        status_q <= ds_ok ? ST_DONE : ST_IGNORED;
      end
    end
  end

  assign m_axis_tdata = {5'd0, jobs_q, late_q, soj_q, wait_q, chosen_q};
  assign m_axis_tuser = status_q;

  // checks
  for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_chk
    a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] == '0 |-> busy_q[g] == '0)
      else $error("server with no jobs is not idle");
  end

  a_pick_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status_q == ST_PLACED |-> {1'b0, chosen_q} < n_act)
    else $error("arrival placed on inactive server");

  a_late_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && late_q |-> status_q == ST_PLACED && soj_q > deadline_q)
    else $error("late flag on a non-arrival or within deadline");

  a_booked_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.kind == KIND_ARRIVAL |=> jobs_q != '0)
    else $error("arrival left a zero job count");

endmodule

>>> bench/job_dispatch_load_balancer_test.sv
// Self-checking bench for job_dispatch_load_balancer: directed and random job and
// completion words under each policy code, checked against a scoreboard predictor.
// Depends on jdlb_pkg and the job_dispatch_load_balancer RTL.
`timescale 1ns / 100ps

module job_dispatch_load_balancer_test;
  import jdlb_pkg::*;

  localparam int NSRV = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYC = 150;
  localparam int RAND_PER_PHASE = 100;
  localparam logic KIND_DONE = ~KIND_ARRIVAL;

  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] sojourn;
    logic              late;
    logic [CNT_W-1:0]  jobs;
    status_e           status;
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  job_dispatch_load_balancer #(.NUM_SERVERS(NSRV)) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the block's registers and per-server state
  logic [2:0]        pol_r = POLICY_RST;
  logic [2:0]        act_r = ACTIVE_RST;
  logic [63:0]       inv_r = INV_RST;
  logic [47:0]       thr_r = THRESH_RST;
  logic [7:0]        ord_r = ORDER_RST;
  logic [TIME_W-1:0] ddl_r = DEADLINE_RST;
  logic [CNT_W-1:0]  cnt_q [NSRV] = '{default: '0};
  logic [TIME_W-1:0] busy_q [NSRV] = '{default: '0};
  logic [1:0]        rr_q = 2'(NSRV - 1);
  logic [1:0]        phase_q = 2'd0;

  item_t    feed_q [$];
  outcome_t booked_q [$];

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  bit hold_req = 1'b0;
  int n_in = 0, n_err = 0, n_arr = 0, n_late = 0, n_done = 0, n_ign = 0;

  function automatic int unsigned used_servers();
    int unsigned n;
    n = act_r;
    if (n == 0) n = 1;
    if (n > NSRV) n = NSRV;
    return n;
  endfunction

  function automatic logic [15:0] inv_of(int unsigned s);
    return inv_r[16*s +: 16];
  endfunction

  function automatic logic [TIME_W-1:0] start_of(int unsigned s, logic [TIME_W-1:0] at);
    return busy_q[s] > at ? busy_q[s] : at;
  endfunction

  function automatic logic [SRV_W-1:0] choose_server(logic [SIZE_W-1:0] size,
                                                     logic [TIME_W-1:0] at);
    int unsigned n, best, nx;
    logic [63:0] key, bk;
    n = used_servers();
    best = 0;
    case (pol_r)
      POL_RR: begin
        nx = rr_q + 1;
        if (nx >= n) nx = 0;
        rr_q = 2'(nx);
        best = nx;
      end
      POL_PATTERN: begin
        best = (phase_q == 2'd1) ? 1 : (phase_q == 2'd3) ? 2 : 0;
        phase_q = phase_q + 2'd1;
      end
      POL_SED: begin
        bk = (64'(cnt_q[0]) + 64'd1) * 64'(inv_of(0));
        for (int i = 1; i < n; i++) begin
          key = (64'(cnt_q[i]) + 64'd1) * 64'(inv_of(i));
          if (key < bk) begin
            bk = key;
            best = i;
          end
        end
      end
      POL_LWL: begin
        bk = 64'(start_of(0, at));
        for (int i = 1; i < n; i++) begin
          key = 64'(start_of(i, at));
          if (key < bk) begin
            bk = key;
            best = i;
          end
        end
      end
      POL_SITA: begin
        best = ord_r[1:0];
        for (int i = 1; i < n; i++)
          if (size > thr_r[16*(i-1) +: 16]) best = ord_r[2*i +: 2];
      end
      default: begin
        bk = 64'(cnt_q[0]);
        for (int i = 1; i < n; i++) begin
          if (64'(cnt_q[i]) < bk) begin
            bk = 64'(cnt_q[i]);
            best = i;
          end
        end
      end
    endcase
    if (best >= n) best = 0;
    return 2'(best);
  endfunction

  function automatic outcome_t book_word(item_t it);
    outcome_t o;
    int unsigned s;
    logic [63:0] st, svc, soj, fin;
    o = '0;
    if (it.kind == KIND_ARRIVAL) begin
      s = choose_server(it.job_size, it.arrival_time);
      st = 64'(start_of(s, it.arrival_time));
      svc = 64'(it.job_size) * 64'(inv_of(s));
      soj = st - 64'(it.arrival_time) + svc;
      fin = st + svc;
      if (soj > 64'(TIME_MAX)) soj = 64'(TIME_MAX);
      if (fin > 64'(TIME_MAX)) fin = 64'(TIME_MAX);
      busy_q[s] = fin[TIME_W-1:0];
      if (cnt_q[s] != CNT_MAX) cnt_q[s] = cnt_q[s] + 1'b1;
      o.server = 2'(s);
      o.delay = 40'(st - 64'(it.arrival_time));
      o.sojourn = soj[TIME_W-1:0];
      o.late = soj > 64'(ddl_r);
      o.jobs = cnt_q[s];
      o.status = ST_PLACED;
    end else begin
      o.server = it.done_server;
      if (cnt_q[it.done_server] != 0) begin
        cnt_q[it.done_server] = cnt_q[it.done_server] - 1'b1;
        if (cnt_q[it.done_server] == 0) busy_q[it.done_server] = '0;
        o.jobs = cnt_q[it.done_server];
        o.status = ST_DONE;
      end else begin
        o.status = ST_IGNORED;
      end
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  // driver: presents the oldest pending word, holds it until taken
  always @(posedge clk_i) begin : drive_p
    item_t nxt;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (feed_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        nxt = feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, nxt.done_server, nxt.arrival_time, nxt.job_size};
        s_axis_tuser <= nxt.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with random stalls and one long hold-off
  always @(posedge clk_i) begin : sink_p
    static bit hold_taken = 1'b0;
    static int hold_left = 0;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYC;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99, 0) >= dst_idle_pct;
    end
  end

  // monitor: books accepted input words, checks accepted results in order
  always @(posedge clk_i) begin : check_p
    item_t    it;
    outcome_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      it.kind = s_axis_tuser;
      it.job_size = s_axis_tdata[15:0];
      it.arrival_time = s_axis_tdata[55:16];
      it.done_server = s_axis_tdata[57:56];
      booked_q.insert(booked_q.size(), book_word(it));
      n_in++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (booked_q.size() == 0) begin
        $error("result word with nothing outstanding");
        n_err++;
      end else begin
        want = booked_q.pop_front();
        check_field("chosen_server", 64'(want.server), 64'(m_axis_tdata[1:0]));
        check_field("wait_time", 64'(want.delay), 64'(m_axis_tdata[41:2]));
        check_field("sojourn_time", 64'(want.sojourn), 64'(m_axis_tdata[81:42]));
        check_field("late", 64'(want.late), 64'(m_axis_tdata[82]));
        check_field("jobs_after", 64'(want.jobs), 64'(m_axis_tdata[98:83]));
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        case (want.status)
          ST_PLACED: begin
            n_arr++;
            if (want.late) n_late++;
          end
          ST_DONE: n_done++;
          default: n_ign++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_p
    static int quiet = 0;
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("timeout: no traffic for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, booked_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_POLICY:    pol_r = val[2:0];
      CFG_ACTIVE:    act_r = val[2:0];
      CFG_INV_RATES: inv_r = val;
      CFG_THRESH:    thr_r = val[47:0];
      CFG_ORDER:     ord_r = val[7:0];
      CFG_DEADLINE:  ddl_r = val[TIME_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (feed_q.size() != 0 || s_axis_tvalid || booked_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void push_arrival(logic [SIZE_W-1:0] size, logic [TIME_W-1:0] at);
    item_t it;
    it.kind = KIND_ARRIVAL;
    it.job_size = size;
    it.arrival_time = at;
    it.done_server = 2'($urandom_range(3, 0));
    feed_q.insert(feed_q.size(), it);
  endfunction

  function automatic void push_done(logic [SRV_W-1:0] srv);
    item_t it;
    logic [63:0] r;
    r = rand64();
    it.kind = KIND_DONE;
    it.job_size = 16'($urandom());
    it.arrival_time = r[TIME_W-1:0];
    it.done_server = srv;
    feed_q.insert(feed_q.size(), it);
  endfunction

  // empties every server queue so that busy-until returns to idle
  task automatic drain_all();
    wait_idle();
    for (int s = 0; s < NSRV; s++)
      repeat (int'(cnt_q[s])) push_done(2'(s));
    wait_idle();
  endtask

  initial begin : stim_p
    logic [TIME_W-1:0] t_now;
    logic [63:0]       v;
    logic [2:0]        act_tab [8];
    int unsigned       roll, inc;
    logic [SIZE_W-1:0] sz;
    act_tab = '{3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd0, 3'd7};
    t_now = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: shortest queue over two servers, zero rates
    push_arrival(16'h0000, 40'h0);
    push_arrival(16'hFFFF, 40'h1_0000);
    push_done(2'd0);
    push_done(2'd3);
    push_done(2'd1);
    push_done(2'd1);
    wait_idle();

    write_reg(CFG_POLICY, 64'(POL_RR));
    write_reg(CFG_ACTIVE, 64'd4);
    write_reg(CFG_INV_RATES, 64'h0001_0080_0100_FFFF);
    write_reg(CFG_DEADLINE, 64'h1_0000);
    t_now = 40'h2_0000;
    foreach (act_tab[k]) if (k < 5) begin
      push_arrival(k == 3 ? 16'hFFFF : 16'(16'h0080 << (k % 3)), t_now);
      t_now = t_now + 40'h8000;
    end
    wait_idle();

    // pattern picks server 2, outside two active servers
    write_reg(CFG_POLICY, 64'(POL_PATTERN));
    write_reg(CFG_ACTIVE, 64'd2);
    repeat (4) push_arrival(16'h0100, t_now);
    wait_idle();

    write_reg(CFG_POLICY, 64'(POL_SED));
    write_reg(CFG_ACTIVE, 64'd4);
    write_reg(CFG_INV_RATES, 64'h0100_0100_0100_0100);
    repeat (3) push_arrival(16'h0200, t_now);
    wait_idle();

    write_reg(CFG_POLICY, 64'(POL_SITA));
    write_reg(CFG_THRESH, 64'h8000_0400_0100);
    write_reg(CFG_ORDER, 64'h1B);
    push_arrival(16'h0000, t_now);
    push_arrival(16'h0100, t_now);
    push_arrival(16'h0101, t_now);
    push_arrival(16'hFFFF, t_now);
    wait_idle();

    // near the top of the time range: finish time saturates
    write_reg(CFG_POLICY, 64'(POL_LWL));
    write_reg(CFG_ACTIVE, 64'd1);
    write_reg(CFG_INV_RATES, '1);
    write_reg(CFG_DEADLINE, 64'(TIME_MAX));
    push_arrival(16'hFFFF, TIME_MAX - 40'h100);
    push_arrival(16'hFFFF, TIME_MAX - 40'h100);
    drain_all();

    t_now = '0;
    for (int p = 0; p < 8; p++) begin
      src_idle_pct = p < 3 ? 9 : p < 6 ? 62 : 0;
      dst_idle_pct = p < 3 ? 62 : p < 6 ? 9 : 0;
      write_reg(CFG_POLICY, 64'(p));
      write_reg(CFG_ACTIVE, 64'(act_tab[p]));
      v = '0;
      for (int l = 0; l < 4; l++) begin
        case ($urandom_range(3, 0))
          0: v[16*l +: 16] = 16'($urandom() & 32'h00FF);
          1: v[16*l +: 16] = 16'($urandom() & 32'h03FF);
          2: v[16*l +: 16] = 16'h0100;
          default: v[16*l +: 16] = 16'($urandom());
        endcase
      end
      write_reg(CFG_INV_RATES, p == 0 ? 64'd0 : p == 7 ? '1 : v);
      write_reg(CFG_THRESH, p == 0 ? 64'd0 : p == 7 ? 64'hFFFF_FFFF_FFFF : rand64());
      write_reg(CFG_ORDER, p == 0 ? 64'd0 : p == 7 ? 64'hFF : 64'($urandom_range(255, 0)));
      write_reg(CFG_DEADLINE, p == 2 ? 64'd0 : p == 7 ? 64'(TIME_MAX)
                                : rand64() & 64'h0FFF_FFFF);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if ($urandom_range(99, 0) < 55) begin
          roll = $urandom_range(15, 0);
          sz = roll == 0 ? 16'h0000 : roll == 1 ? 16'hFFFF : 16'($urandom());
          roll = $urandom_range(7, 0);
          inc = roll == 0 ? 0 : roll == 7 ? ($urandom() & 32'h0FFF_FFFF)
                                          : ($urandom() & 32'h000F_FFFF);
          t_now = t_now + 40'(inc);
          push_arrival(sz, t_now);
        end else if ($urandom_range(4, 0) != 0) begin
          push_done(2'($urandom_range(used_servers() - 1, 0)));
        end else begin
          push_done(2'($urandom_range(3, 0)));
        end
      end
      if (p == 7) hold_req = 1'b1;
      wait_idle();
    end

    $display("summary: %0d words in, %0d jobs placed (%0d late), %0d completions, %0d ignored",
             n_in, n_arr, n_late, n_done, n_ign);
    $display("summary: every policy code, several active counts, time saturation, long stall");
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
